/* sv/mtbd_pkg.sv */
`timescale 1ns / 1ps
package mtbd_pkg;
   localparam int N_WORDS = 624;
   localparam int M_OFFSET = 397;
   localparam int ADDR_W = 10;
   localparam int BOUND_W = 31;
   localparam logic [31:0] MATRIX_A = 32'h9908b0df;
   localparam logic [31:0] UPPER_MASK = 32'h80000000;
   localparam logic [31:0] LOWER_MASK = 32'h7fffffff;
   localparam logic [31:0] INIT_MUL = 32'd1812433253;
   localparam logic [31:0] SEED_RESET = 32'd5489;
   localparam logic [31:0] TEMPER_B = 32'h9d2c5680;
   localparam logic [31:0] TEMPER_C = 32'hefc60000;
   localparam logic [31:0] ALL_ONES = 32'hFFFFFFFF;
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(N_WORDS - 1);
   localparam logic [ADDR_W-1:0] N_ADDR = ADDR_W'(N_WORDS);

   typedef logic [ADDR_W-1:0] addr_type;

   // wrap an address that may run up to twice the table size
   function automatic addr_type wrap_addr(input logic [ADDR_W:0] a);
      if (a >= (ADDR_W + 1)'(N_WORDS)) begin
         return ADDR_W'(a - (ADDR_W + 1)'(N_WORDS));
      end
      return a[ADDR_W-1:0];
   endfunction

   function automatic logic [31:0] mix(input logic [31:0] hi_w, input logic [31:0] lo_w,
                                       input logic [31:0] far_w);
      logic [31:0] y;
      logic [31:0] v;
      y = (hi_w & UPPER_MASK) | (lo_w & LOWER_MASK);
      v = far_w ^ (y >> 1);
      if (y[0]) begin
         v = v ^ MATRIX_A;
      end
      return v;
   endfunction

   function automatic logic [31:0] temper(input logic [31:0] w);
      logic [31:0] y;
      y = w ^ (w >> 11);
      y = y ^ ((y << 7) & TEMPER_B);
      y = y ^ ((y << 15) & TEMPER_C);
      y = y ^ (y >> 18);
      return y;
   endfunction
endpackage

/* sv/mtbd_req_if.sv */
`timescale 1ns / 1ps
interface mtbd_req_if import mtbd_pkg::*; ();
   logic valid;
   logic ready;
   logic [BOUND_W-1:0] bound;
   modport source (output valid, output bound, input ready);
   modport sink (input valid, input bound, output ready);
endinterface

/* sv/mtbd_rsp_if.sv */
`timescale 1ns / 1ps
interface mtbd_rsp_if import mtbd_pkg::*; ();
   logic valid;
   logic ready;
   logic [BOUND_W-1:0] value;
   modport source (output valid, output value, input ready);
   modport sink (input valid, input value, output ready);
endinterface

/* sv/mt19937_bounded_draw.sv */
`timescale 1ns / 1ps
// Flow: bound 0 or 1 posts a zero result straight from the done state; otherwise the
// rejection-limit divider runs, then each word is read, tempered and tested against the
// limit, a rejected word draws again, and the remainder divider forms the result, which
// is then posted; the state twists first whenever the table is used up. Throughput: one
// transaction at a time; the next is taken once the result posts and the block is idle.
// Reset (synchronous, active high) and each seed write start a fill of the RAM.
module mt19937_bounded_draw import mtbd_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic csr_we,
   input  logic [31:0] csr_wdata,
   mtbd_req_if.sink req_chan,
   mtbd_rsp_if.source rsp_chan
);
   localparam logic [4:0] S_INIT0 = 5'd0;
   localparam logic [4:0] S_IMUL = 5'd1;
   localparam logic [4:0] S_IADD = 5'd2;
   localparam logic [4:0] S_IDLE = 5'd3;
   localparam logic [4:0] S_LIM = 5'd4;
   localparam logic [4:0] S_DRAW = 5'd5;
   localparam logic [4:0] S_TEMP = 5'd6;
   localparam logic [4:0] S_TEST = 5'd7;
   localparam logic [4:0] S_MOD = 5'd8;
   localparam logic [4:0] S_DONE = 5'd9;
   localparam logic [4:0] S_TW0 = 5'd10;
   localparam logic [4:0] S_TWC = 5'd11;
   localparam logic [4:0] S_TWN = 5'd12;
   localparam logic [4:0] S_TWF = 5'd13;
   localparam logic [4:0] S_RDW = 5'd14;

   logic [31:0] mem [N_WORDS];
   logic [31:0] rdata_ff;
   addr_type rd_addr;
   addr_type wr_addr;
   logic [31:0] wr_data;
   logic wr_en;

   logic [4:0] state_ff, state_in;
   logic [31:0] seed_ff;
   addr_type idx_ff, idx_in;
   addr_type cnt_ff, cnt_in;
   logic [31:0] p_ff, p_in;
   logic [31:0] prod_ff, prod_in;
   logic [31:0] cur_ff, cur_in;
   logic [31:0] nxt_ff, nxt_in;
   logic [BOUND_W-1:0] bound_ff, bound_in;
   logic [31:0] limit_ff, limit_in;
   logic [31:0] dvd_ff, dvd_in;
   logic [31:0] rem_ff, rem_in;
   logic [4:0] step_ff, step_in;
   logic [31:0] r_ff, r_in;
   logic rsp_valid_ff, rsp_valid_in;
   logic [BOUND_W-1:0] rsp_value_ff, rsp_value_in;

   logic [32:0] shifted;
   logic [32:0] rem_next;
   logic [31:0] init_word;

   // hold seed
   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= SEED_RESET;
      end else if (csr_we) begin
         seed_ff <= csr_wdata;
      end
   end

   // state RAM: one write, one registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rdata_ff <= mem[rd_addr];
   end

   // one restoring divider step
   assign shifted = {rem_ff, dvd_ff[31]};
   assign rem_next = (shifted >= {2'b00, bound_ff}) ? shifted - {2'b00, bound_ff} : shifted;
   assign init_word = prod_ff + {22'd0, cnt_ff};

   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff;
      cnt_in = cnt_ff;
      p_in = p_ff;
      prod_in = prod_ff;
      cur_in = cur_ff;
      nxt_in = nxt_ff;
      bound_in = bound_ff;
      limit_in = limit_ff;
      dvd_in = dvd_ff;
      rem_in = rem_ff;
      step_in = step_ff;
      r_in = r_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      rd_addr = idx_ff;
      wr_addr = cnt_ff;
      wr_data = init_word;
      wr_en = 1'b0;

      // drop response once taken
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_INIT0: begin
            wr_addr = '0;
            wr_data = seed_ff;
            wr_en = 1'b1;
            p_in = seed_ff;
            cnt_in = ADDR_W'(1);
            state_in = S_IMUL;
         end
         S_IMUL: begin
            prod_in = INIT_MUL * (p_ff ^ (p_ff >> 30));
            state_in = S_IADD;
         end
         S_IADD: begin
            wr_en = 1'b1;
            p_in = init_word;
            if (cnt_ff == LAST_ADDR) begin
               idx_in = N_ADDR;
               state_in = S_IDLE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
               state_in = S_IMUL;
            end
         end
         S_IDLE: begin
            if (req_chan.valid) begin
               bound_in = req_chan.bound;
               if (req_chan.bound <= BOUND_W'(1)) begin
                  r_in = '0;
                  state_in = S_DONE;
               end else begin
                  dvd_in = ALL_ONES;
                  rem_in = '0;
                  step_in = '0;
                  state_in = S_LIM;
               end
            end
         end
         S_LIM: begin
            rem_in = rem_next[31:0];
            dvd_in = {dvd_ff[30:0], 1'b0};
            step_in = step_ff + 1'b1;
            if (step_ff == 5'd31) begin
               limit_in = ALL_ONES - rem_next[31:0];
               state_in = S_DRAW;
            end
         end
         S_DRAW: begin
            if (idx_ff >= N_ADDR) begin
               state_in = S_TW0;
            end else begin
               state_in = S_RDW;
            end
         end
         S_RDW: begin
            // read issued at idx_ff this cycle, data next
            state_in = S_TEMP;
         end
         S_TEMP: begin
            r_in = temper(rdata_ff);
            idx_in = idx_ff + 1'b1;
            state_in = S_TEST;
         end
         S_TEST: begin
            if (r_ff >= limit_ff) begin
               state_in = S_DRAW;
            end else begin
               dvd_in = r_ff;
               rem_in = '0;
               step_in = '0;
               state_in = S_MOD;
            end
         end
         S_MOD: begin
            rem_in = rem_next[31:0];
            dvd_in = {dvd_ff[30:0], 1'b0};
            step_in = step_ff + 1'b1;
            if (step_ff == 5'd31) begin
               r_in = rem_next[31:0];
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = r_ff[BOUND_W-1:0];
               state_in = S_IDLE;
            end
         end
         S_TW0: begin
            rd_addr = '0;
            cnt_in = '0;
            state_in = S_TWC;
         end
         S_TWC: begin
            cur_in = rdata_ff;
            rd_addr = ADDR_W'(1);
            state_in = S_TWN;
         end
         S_TWN: begin
            nxt_in = rdata_ff;
            rd_addr = wrap_addr({1'b0, cnt_ff} + (ADDR_W + 1)'(M_OFFSET));
            state_in = S_TWF;
         end
         S_TWF: begin
            wr_en = 1'b1;
            wr_data = mix(cur_ff, nxt_ff, rdata_ff);
            cur_in = nxt_ff;
            rd_addr = wrap_addr({1'b0, cnt_ff} + (ADDR_W + 1)'(2));
            if (cnt_ff == LAST_ADDR) begin
               idx_in = '0;
               state_in = S_DRAW;
            end else begin
               cnt_in = cnt_ff + 1'b1;
               state_in = S_TWN;
            end
         end
         default: begin
            state_in = S_INIT0;
         end
      endcase

      // restart the fill on a seed write
      if (csr_we) begin
         state_in = S_INIT0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_INIT0;
         rsp_valid_ff <= 1'b0;
         idx_ff <= N_ADDR;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         idx_ff <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      p_ff <= p_in;
      prod_ff <= prod_in;
      cur_ff <= cur_in;
      nxt_ff <= nxt_in;
      bound_ff <= bound_in;
      limit_ff <= limit_in;
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      step_ff <= step_in;
      r_ff <= r_in;
      rsp_value_ff <= rsp_value_in;
   end

   assign req_chan.ready = (state_ff == S_IDLE) && !csr_we;
   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.value = rsp_value_ff;

   a_idx_range: assert property (@(posedge clock) disable iff (reset) idx_ff <= N_ADDR)
      else $error("word index past table end");
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> !req_chan.ready)
      else $error("second request taken while busy");
   a_value_below: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE) && (bound_ff > BOUND_W'(1)) |-> r_ff < {1'b0, bound_ff})
      else $error("draw not below bound");
endmodule
